// ===== src/befp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and frame constants for the button event frame parser
package befp_pkg;

	localparam logic [7:0] PREFIX_A      = 8'h31;
	localparam logic [7:0] PREFIX_B      = 8'h60;
	localparam logic [7:0] FRAME_MAGIC   = 8'hFF;
	localparam logic [7:0] FRAME_CMD     = 8'h22;
	localparam logic [7:0] FRAME_LEN     = 8'h03;
	localparam logic [7:0] FRAME_PAD     = 8'h00;
	localparam logic [7:0] STATE_PRESSED = 8'h01;
	localparam int         POS_W         = 4;
	localparam logic [POS_W-1:0] POS_MAX = 4'd15;

	// frame byte numbers, the magic byte is number zero
	localparam logic [POS_W-1:0] IDX_MAGIC = 4'd0;
	localparam logic [POS_W-1:0] IDX_CMD   = 4'd1;
	localparam logic [POS_W-1:0] IDX_LEN   = 4'd2;
	localparam logic [POS_W-1:0] IDX_ID    = 4'd3;
	localparam logic [POS_W-1:0] IDX_PAD   = 4'd4;
	localparam logic [POS_W-1:0] IDX_STATE = 4'd5;
	localparam logic [POS_W-1:0] IDX_SUM   = 4'd6;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             prefix_seen;
		logic [7:0]       first_byte;
		logic             header_ok;
		logic [7:0]       running_sum;
		logic [7:0]       held_id;
		logic             held_pressed;
		logic             frame_good;
	} trk_state_t;

	localparam trk_state_t TRK_RESET = '{
		pos:          '0,
		prefix_seen:  1'b0,
		first_byte:   8'h00,
		header_ok:    1'b1,
		running_sum:  8'h00,
		held_id:      8'h00,
		held_pressed: 1'b0,
		frame_good:   1'b0
	};

	typedef struct packed {
		logic       event_valid;
		logic [7:0] button_id;
		logic       pressed;
	} evt_result_t;

endpackage

// ===== src/befp_track.sv =====
`timescale 1ns / 1ps
// per-byte frame tracking: position, header checks, checksum and held fields
module befp_track import befp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        push,
	output evt_result_t result
);

	trk_state_t st_q;
	trk_state_t nxt;
	logic [POS_W-1:0] idx;

	function automatic trk_state_t take_byte(trk_state_t s, logic [POS_W-1:0] i,
			logic [7:0] b);
		trk_state_t r;
		r = s;
		case (i)
			IDX_MAGIC: begin
				if (b != FRAME_MAGIC) r.header_ok = 1'b0;
			end
			IDX_CMD: begin
				if (b != FRAME_CMD) r.header_ok = 1'b0;
				r.running_sum = s.running_sum + b;
			end
			IDX_LEN: begin
				if (b != FRAME_LEN) r.header_ok = 1'b0;
				r.running_sum = s.running_sum + b;
			end
			IDX_ID: begin
				r.held_id = b;
				r.running_sum = s.running_sum + b;
			end
			IDX_PAD: begin
				if (b != FRAME_PAD) r.header_ok = 1'b0;
				r.running_sum = s.running_sum + b;
			end
			IDX_STATE: begin
				r.held_pressed = (b == STATE_PRESSED);
				r.running_sum = s.running_sum + b;
			end
			IDX_SUM: begin
				r.frame_good = s.header_ok && (b == s.running_sum);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// frame byte number skips the two prefix bytes when they were seen
	assign idx = st_q.prefix_seen ? st_q.pos - POS_W'(2) : st_q.pos;

	always_comb begin
		nxt = st_q;
		if (st_q.pos == '0) begin
			nxt.first_byte = data_byte;
		end else if (st_q.pos == POS_W'(1)) begin
			if (st_q.first_byte == PREFIX_A && data_byte == PREFIX_B) begin
				nxt.prefix_seen = 1'b1;
			end else begin
				// no prefix: held first byte and this one are frame bytes zero and one
				nxt = take_byte(nxt, IDX_MAGIC, st_q.first_byte);
				nxt = take_byte(nxt, IDX_CMD, data_byte);
			end
		end else if (st_q.pos < POS_MAX) begin
			nxt = take_byte(nxt, idx, data_byte);
		end
		if (st_q.pos < POS_MAX) nxt.pos = st_q.pos + POS_W'(1);
	end

	assign push               = accept && last_byte;
	assign result.event_valid = nxt.frame_good;
	assign result.button_id   = nxt.frame_good ? nxt.held_id : 8'h00;
	assign result.pressed     = nxt.frame_good && nxt.held_pressed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= TRK_RESET;
		end else if (accept) begin
			st_q <= last_byte ? TRK_RESET : nxt;
		end
	end

endmodule

// ===== src/befp_outbuf.sv =====
`timescale 1ns / 1ps
// two-entry result buffer: output register plus skid register
module befp_outbuf import befp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  evt_result_t push_data,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output evt_result_t out_data
);

	logic        main_valid_q;
	logic        skid_valid_q;
	evt_result_t main_q;
	evt_result_t skid_q;
	logic        pop;

	assign pop       = main_valid_q && out_ready;
	assign room      = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) skid_valid_q <= 1'b1;
			else main_valid_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) main_q <= skid_q;
			else if (push) main_q <= push_data;
		end else if (push) begin
			if (main_valid_q) skid_q <= push_data;
			else main_q <= push_data;
		end
	end

endmodule

// ===== src/button_event_frame_parser.sv =====
`timescale 1ns / 1ps
// Button event frame parser, top level.
// Input channel: one packet byte per beat on data_byte, last_byte marks the
// packet's final beat. An optional 31 60 prefix is skipped; the frame must be
// FF 22 03 id 00 state sum with sum the 8-bit sum of the five bytes after FF.
// Output channel: one beat per packet, sent for the final byte only, carrying
// event_valid, button_id (0 when invalid) and pressed.
// Throughput: one input beat per cycle while in_ready is high; the byte
// checks are a single register stage. A result enters the result buffer
// when its final byte is taken and shows on out_valid from the output register.
// A two-entry result buffer sits on the output; in_ready drops only while both
// entries hold results, so bytes keep flowing while one result waits.
// Reset (arst_n low) returns the parser to the start of a packet and drops
// any buffered results.
module button_event_frame_parser import befp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       event_valid,
	output logic [7:0] button_id,
	output logic       pressed
);

	logic        accept;
	logic        push;
	evt_result_t trk_result;
	evt_result_t out_data;

	assign accept = in_valid && in_ready;

	befp_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push),
		.result    (trk_result)
	);

	befp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (trk_result),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign event_valid = out_data.event_valid;
	assign button_id   = out_data.button_id;
	assign pressed     = out_data.pressed;

endmodule

// ===== src/befp_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the button event frame parser
module befp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       event_valid,
	input logic [7:0] button_id,
	input logic       pressed
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_valid)
			&& $stable(button_id) && $stable(pressed))
		else $error("stalled result beat changed");

	// invalid events carry zero id and not pressed
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_valid |-> button_id == 8'h00 && !pressed)
		else $error("invalid event with nonzero fields");

	// a result appears only after the final byte of a packet was taken
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && last_byte))
		else $error("result without a final byte");

	// input stalls only while a result is pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

endmodule

bind button_event_frame_parser befp_checker u_befp_checker (.*);

// ===== sim/button_event_frame_parser_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the button event frame parser
module button_event_frame_parser_test import befp_pkg::*; ();

	class button_event_scoreboard;
		// parser state as the block should hold it
		logic [POS_W-1:0] pos;
		logic             pfx;
		logic [7:0]       first_b;
		logic             hdr_ok;
		logic [7:0]       sum;
		logic [7:0]       id;
		logic             prs;
		logic             good;
		evt_result_t      pending_events[$];
		int               errors;
		int               checked;
		int               valid_events;
		int               pressed_events;

		function new();
			errors = 0;
			checked = 0;
			valid_events = 0;
			pressed_events = 0;
			restart();
		endfunction

		function void restart();
			pos = '0;
			pfx = 1'b0;
			first_b = 8'h00;
			hdr_ok = 1'b1;
			sum = 8'h00;
			id = 8'h00;
			prs = 1'b0;
			good = 1'b0;
		endfunction

		function void absorb_frame_byte(logic [POS_W-1:0] idx, logic [7:0] b);
			case (idx)
				IDX_MAGIC: begin
					if (b != FRAME_MAGIC) hdr_ok = 1'b0;
				end
				IDX_CMD: begin
					if (b != FRAME_CMD) hdr_ok = 1'b0;
					sum = sum + b;
				end
				IDX_LEN: begin
					if (b != FRAME_LEN) hdr_ok = 1'b0;
					sum = sum + b;
				end
				IDX_ID: begin
					id = b;
					sum = sum + b;
				end
				IDX_PAD: begin
					if (b != FRAME_PAD) hdr_ok = 1'b0;
					sum = sum + b;
				end
				IDX_STATE: begin
					prs = (b == STATE_PRESSED);
					sum = sum + b;
				end
				IDX_SUM: begin
					good = hdr_ok && (b == sum);
				end
				default: begin
				end
			endcase
		endfunction

		task report(string what);
			errors++;
			$display("%0t mismatch: %s", $realtime, what);
		endtask

		task note_byte(logic [7:0] b, logic fin);
			evt_result_t r;
			if (pos == 0) begin
				first_b = b;
			end else if (pos == 1) begin
				// prefix decision needs both of the first two bytes
				if (first_b == PREFIX_A && b == PREFIX_B) begin
					pfx = 1'b1;
				end else begin
					absorb_frame_byte(IDX_MAGIC, first_b);
					absorb_frame_byte(IDX_CMD, b);
				end
			end else if (pos < POS_MAX) begin
				absorb_frame_byte(pfx ? pos - 4'd2 : pos, b);
			end
			if (pos < POS_MAX) pos = pos + 4'd1;
			if (fin) begin
				r.event_valid = good;
				r.button_id = good ? id : 8'h00;
				r.pressed = good && prs;
				pending_events.insert(pending_events.size(), r);
				if (r.event_valid) valid_events++;
				if (r.pressed) pressed_events++;
				restart();
			end
		endtask

		task check_result(logic ev, logic [7:0] bid, logic pr);
			evt_result_t want;
			if (pending_events.size() == 0) begin
				report($sformatf("result with none expected: valid=%0b id=%02h pressed=%0b",
					ev, bid, pr));
				return;
			end
			want = pending_events.pop_front();
			checked++;
			if (ev !== want.event_valid)
				report($sformatf("event_valid %0b, want %0b", ev, want.event_valid));
			if (bid !== want.button_id)
				report($sformatf("button_id %02h, want %02h", bid, want.button_id));
			if (pr !== want.pressed)
				report($sformatf("pressed %0b, want %0b", pr, want.pressed));
		endtask

		task flag_leftovers();
			if (pending_events.size() != 0)
				report($sformatf("%0d results never arrived", pending_events.size()));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       event_valid;
	logic [7:0] button_id;
	logic       pressed;

	button_event_scoreboard sb = new();

	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         bytes_sent = 0;
	int         packets_sent = 0;
	logic [7:0] pkt[$];

	button_event_frame_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_valid (event_valid),
		.button_id   (button_id),
		.pressed     (pressed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_byte(data_byte, last_byte);
			if (out_valid && out_ready) sb.check_result(event_valid, button_id, pressed);
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic final_beat);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		last_byte <= final_beat;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		pkt.delete();
		packets_sent++;
	endtask

	task automatic push_frame(input logic [7:0] bid, input logic [7:0] st, input bit sum_ok);
		logic [7:0] s;
		s = FRAME_CMD + FRAME_LEN + bid + FRAME_PAD + st;
		if (!sum_ok) s = s + 8'($urandom_range(1, 255));
		pkt.insert(pkt.size(), FRAME_MAGIC);
		pkt.insert(pkt.size(), FRAME_CMD);
		pkt.insert(pkt.size(), FRAME_LEN);
		pkt.insert(pkt.size(), bid);
		pkt.insert(pkt.size(), FRAME_PAD);
		pkt.insert(pkt.size(), st);
		pkt.insert(pkt.size(), s);
	endtask

	task automatic push_noise(input int n);
		for (int i = 0; i < n; i++) pkt.insert(pkt.size(), 8'($urandom_range(255)));
	endtask

	task automatic build_good_packet(input bit sum_ok);
		logic [7:0] st;
		int         pick;
		pick = $urandom_range(3);
		if ($urandom_range(1)) begin
			pkt.insert(pkt.size(), PREFIX_A);
			pkt.insert(pkt.size(), PREFIX_B);
		end
		if (pick == 0) st = FRAME_PAD;
		else if (pick == 1) st = STATE_PRESSED;
		else st = 8'($urandom_range(255));
		push_frame(8'($urandom_range(255)), st, sum_ok);
		// mostly a few trailing bytes, now and then enough to saturate the position
		if ($urandom_range(9) == 0) push_noise($urandom_range(4, 12));
		else push_noise($urandom_range(0, 2));
	endtask

	task automatic random_packet();
		int kind;
		int keep;
		int at;
		kind = $urandom_range(99);
		if (kind < 60) begin
			build_good_packet($urandom_range(99) < 85);
		end else if (kind < 80) begin
			build_good_packet(1'b1);
			if ($urandom_range(1)) begin
				keep = $urandom_range(1, pkt.size() - 1);
				while (pkt.size() > keep) void'(pkt.pop_back());
			end else begin
				at = $urandom_range(0, pkt.size() - 1);
				pkt[at] = pkt[at] ^ 8'($urandom_range(1, 255));
			end
		end else begin
			if ($urandom_range(3) == 0) begin
				pkt.insert(pkt.size(), PREFIX_A);
				if ($urandom_range(1)) pkt.insert(pkt.size(), PREFIX_B);
			end
			push_noise($urandom_range(1, 20));
		end
	endtask

	task automatic run_phase(input int idle_pct, input int recv_stall, input int n_bytes);
		int start;
		send_idle_pct = idle_pct;
		stall_pct <= recv_stall;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			random_packet();
			send_packet();
		end
	endtask

	// hold the input off until every outstanding result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_events.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte packet: prefix impossible, too short
		pkt.insert(pkt.size(), PREFIX_A);
		send_packet();
		// short packet
		pkt.insert(pkt.size(), FRAME_MAGIC);
		pkt.insert(pkt.size(), FRAME_CMD);
		pkt.insert(pkt.size(), FRAME_LEN);
		send_packet();
		// plain frame, top id, pressed
		push_frame(8'hFF, STATE_PRESSED, 1'b1);
		send_packet();
		// prefixed frame with trailing bytes past the saturation point
		pkt.insert(pkt.size(), PREFIX_A);
		pkt.insert(pkt.size(), PREFIX_B);
		push_frame(8'h00, FRAME_PAD, 1'b1);
		pkt.insert(pkt.size(), 8'hFF);
		pkt.insert(pkt.size(), 8'h00);
		pkt.insert(pkt.size(), 8'hA5);
		pkt.insert(pkt.size(), 8'h5A);
		pkt.insert(pkt.size(), FRAME_MAGIC);
		pkt.insert(pkt.size(), 8'h01);
		pkt.insert(pkt.size(), 8'hFE);
		send_packet();
		drain();

		run_phase(28, 65, 410);
		drain();
		run_phase(65, 28, 410);
		drain();
		run_phase(0, 0, 410);
		drain();
		repeat (20) @(posedge clk);

		sb.flag_leftovers();
		$display("sent %0d bytes in %0d packets: plain, prefixed, short, long, corrupted, noise",
			bytes_sent, packets_sent);
		$display("checked %0d results, %0d valid events, %0d pressed",
			sb.checked, sb.valid_events, sb.pressed_events);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout waiting on the parser");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/befp_pkg.sv
src/befp_track.sv
src/befp_outbuf.sv
src/button_event_frame_parser.sv
src/befp_checker.sv
sim/button_event_frame_parser_test.sv
